// ===== design/msps_pkg.sv =====
// Shared types and constants for the periodic trigger scheduler.
// No dependencies; used by every module in the design folder.
package msps_pkg;

  localparam int unsigned TimeW   = 64;  // timestamps and due times
  localparam int unsigned IvW     = 48;  // source interval
  localparam int unsigned TypeW   = 8;   // trigger type code
  localparam int unsigned SrcIdxW = 2;   // source index
  localparam int unsigned SrcSlots = 4;  // register slots per source bank
  localparam int unsigned CfgIdxW = 3;   // configuration register index
  localparam int unsigned CfgW    = 48;  // widest configuration register

  localparam int unsigned NumSourcesDef = 4;

  // stagger added per source index to the first-tick base before rounding up
  localparam logic [TimeW-1:0] StartStagger = 64'd5000;

  // configuration register indexes (bank bases)
  localparam logic [CfgIdxW-1:0] CfgInterval0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTypeCode0 = 3'd4;

  // remainder divider
  localparam int unsigned DivSteps = TimeW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // controller to datapath
  typedef struct packed {
    logic               load_now;     // capture the accepted timestamp
    logic               div_start;    // launch a remainder division
    logic               div_init;     // division is a first-tick start time
    logic               due_write;    // store the new due time
    logic               set_started;  // first tick finished
    logic               mark;         // build the fire mask
    logic               pick_go;      // emit the earliest firing source
    logic [SrcIdxW-1:0] src_idx;      // source under first-tick set-up
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic started;
    logic src_en;     // src_idx is in range and enabled
    logic div_busy;
    logic div_done;
    logic fire_any;   // sources still to emit on this tick
    logic out_free;   // output register can take a word
  } ctrl_sts_t;

endpackage

// ===== design/msps_rem_div.sv =====
// Restoring remainder divider, one dividend bit per cycle.
// Depends on msps_pkg for widths and step count.
module msps_rem_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [msps_pkg::TimeW-1:0]  dividend_i,
  input  logic [msps_pkg::IvW-1:0]    divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [msps_pkg::IvW-1:0]    rem_o
);

  logic [msps_pkg::TimeW-1:0]   dvd_q;
  logic [msps_pkg::IvW-1:0]     dvs_q;
  logic [msps_pkg::IvW-1:0]     rem_q, rem_d;
  logic [msps_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q, done_q;
  logic [msps_pkg::IvW:0]       trial, diff;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[msps_pkg::TimeW-1]};
    diff  = trial - {1'b0, dvs_q};
    rem_d = (trial >= {1'b0, dvs_q}) ? diff[msps_pkg::IvW-1:0] : trial[msps_pkg::IvW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == msps_pkg::DivCntW'(msps_pkg::DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[msps_pkg::TimeW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/msps_datapath.sv =====
// Scheduler datapath: configuration bank, due times, fire mask, earliest
// pick and output register. Depends on msps_pkg and msps_rem_div.
module msps_datapath #(
  parameter int unsigned NUM_SOURCES = msps_pkg::NumSourcesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msps_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic [msps_pkg::TimeW-1:0]     now_time_i,
  input  msps_pkg::ctrl_cmd_t            cmd_i,
  output msps_pkg::ctrl_sts_t            sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [msps_pkg::TimeW-1:0]     trigger_time_o,
  output logic [msps_pkg::TypeW-1:0]     trigger_type_o,
  output logic [msps_pkg::SrcIdxW-1:0]   source_index_o,
  output logic                           last_of_tick_o
);

  localparam int unsigned S = msps_pkg::SrcSlots;

  logic [msps_pkg::IvW-1:0]     interval_q [S];
  logic [msps_pkg::TypeW-1:0]   type_q     [S];
  logic [msps_pkg::TimeW-1:0]   due_q      [S];
  logic                         started_q;
  logic [S-1:0]                 fire_q;
  logic [msps_pkg::TimeW-1:0]   now_q, base_q;
  logic [msps_pkg::SrcIdxW-1:0] tgt_q;

  logic                         out_valid_q, out_last_q;
  logic [msps_pkg::TimeW-1:0]   out_time_q;
  logic [msps_pkg::TypeW-1:0]   out_type_q;
  logic [msps_pkg::SrcIdxW-1:0] out_src_q;

  logic [S-1:0]                 fire_new, pick_oh;
  logic [msps_pkg::SrcIdxW-1:0] pick, pick_lo, pick_hi, div_tgt;
  logic                         lo_v, hi_v;
  logic [msps_pkg::TimeW-1:0]   init_base, div_base;
  logic                         div_busy, div_done;
  logic [msps_pkg::IvW-1:0]     div_rem;
  logic                         out_free;

  // fire mask: enabled, in range and due
  always_comb begin
    for (int i = 0; i < S; i++) begin
      fire_new[i] = (i < NUM_SOURCES) && (interval_q[i] != '0) && (due_q[i] <= now_q);
    end
  end

  // earliest firing source, lower index on a tie
  always_comb begin
    lo_v    = fire_q[0] | fire_q[1];
    pick_lo = (fire_q[0] && (!fire_q[1] || due_q[0] <= due_q[1])) ? 2'd0 : 2'd1;
    hi_v    = fire_q[2] | fire_q[3];
    pick_hi = (fire_q[2] && (!fire_q[3] || due_q[2] <= due_q[3])) ? 2'd2 : 2'd3;
    pick    = (lo_v && (!hi_v || due_q[pick_lo] <= due_q[pick_hi])) ? pick_lo : pick_hi;
    pick_oh = S'(1) << pick;
  end

  assign init_base = now_q + (msps_pkg::TimeW'(cmd_i.src_idx) * msps_pkg::StartStagger);
  assign div_tgt   = cmd_i.div_init ? cmd_i.src_idx : pick;
  assign div_base  = cmd_i.div_init ? init_base : due_q[pick];
  assign out_free  = !out_valid_q || !out_stall_i;

  msps_rem_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_base),
    .divisor_i  (interval_q[div_tgt]),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // configuration bank and scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < S; i++) begin
        interval_q[i] <= '0;
        type_q[i]     <= '0;
        due_q[i]      <= '0;
      end
      started_q <= 1'b0;
      fire_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i >= msps_pkg::CfgTypeCode0) begin
          type_q[cfg_idx_i[msps_pkg::SrcIdxW-1:0]] <= cfg_wdata_i[msps_pkg::TypeW-1:0];
        end else begin
          interval_q[cfg_idx_i[msps_pkg::SrcIdxW-1:0]] <= cfg_wdata_i[msps_pkg::IvW-1:0];
        end
      end
      // next multiple: base - (base mod iv) + iv, wrapping
      if (cmd_i.due_write) begin
        due_q[tgt_q] <= base_q - {{(msps_pkg::TimeW-msps_pkg::IvW){1'b0}}, div_rem}
                               + {{(msps_pkg::TimeW-msps_pkg::IvW){1'b0}}, interval_q[tgt_q]};
      end
      if (cmd_i.set_started) begin
        started_q <= 1'b1;
      end
      if (cmd_i.mark) begin
        fire_q <= fire_new;
      end else if (cmd_i.pick_go) begin
        fire_q <= fire_q & ~pick_oh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      now_q <= now_time_i;
    end
    if (cmd_i.div_start) begin
      base_q <= div_base;
      tgt_q  <= div_tgt;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pick_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick_go) begin
      out_time_q <= due_q[pick];
      out_type_q <= type_q[pick];
      out_src_q  <= pick;
      out_last_q <= ((fire_q & ~pick_oh) == '0);
    end
  end

  always_comb begin
    sts_o.started  = started_q;
    sts_o.src_en   = (int'(cmd_i.src_idx) < NUM_SOURCES) && (interval_q[cmd_i.src_idx] != '0);
    sts_o.div_busy = div_busy;
    sts_o.div_done = div_done;
    sts_o.fire_any = (fire_q != '0);
    sts_o.out_free = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign trigger_time_o = out_time_q;
  assign trigger_type_o = out_type_q;
  assign source_index_o = out_src_q;
  assign last_of_tick_o = out_last_q;

endmodule

// ===== design/msps_ctrl.sv =====
// Scheduler controller: sequences first-tick set-up, marking and emission.
// Depends on msps_pkg for the command and status structs.
module msps_ctrl #(
  parameter int unsigned NUM_SOURCES = msps_pkg::NumSourcesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  msps_pkg::ctrl_sts_t  sts_i,
  output msps_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_IDIV = 6'b000100,
    S_MARK = 6'b001000,
    S_PICK = 6'b010000,
    S_ADIV = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  logic [msps_pkg::SrcIdxW-1:0] idx_q, idx_d;
  logic                         idx_last;

  assign idx_last = (idx_q == msps_pkg::SrcIdxW'(NUM_SOURCES - 1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.src_idx = idx_q;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_now = 1'b1;
          idx_d   = '0;
          state_d = sts_i.started ? S_MARK : S_INIT;
        end
      end
      S_INIT: begin
        if (sts_i.src_en) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_init  = 1'b1;
          state_d = S_IDIV;
        end else if (idx_last) begin
          cmd_o.set_started = 1'b1;
          state_d = S_MARK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDIV: begin
        if (sts_i.div_done) begin
          cmd_o.due_write = 1'b1;
          if (idx_last) begin
            cmd_o.set_started = 1'b1;
            state_d = S_MARK;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_INIT;
          end
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        state_d = S_PICK;
      end
      S_PICK: begin
        if (!sts_i.fire_any) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.pick_go   = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d = S_ADIV;
        end
      end
      S_ADIV: begin
        if (sts_i.div_done) begin
          cmd_o.due_write = 1'b1;
          state_d = S_PICK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== design/multi_source_periodic_trigger_scheduler.sv =====
// Periodic trigger scheduler, up to four sources, one timestamp word in.
// Each emitted word needs a 64-step remainder division in the shared divider
// for the next due time of its source. On the first tick each enabled source
// also needs a division for its start time.
// Reset (async, active low) clears intervals, type codes, due times and the
// started flag; the next tick after reset computes the start times.
module multi_source_periodic_trigger_scheduler #(
  parameter int unsigned NUM_SOURCES = msps_pkg::NumSourcesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [msps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msps_pkg::CfgW-1:0]      cfg_wdata_i,
  // timestamp ticks
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [msps_pkg::TimeW-1:0]     now_time_i,
  // trigger words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [msps_pkg::TimeW-1:0]     trigger_time_o,
  output logic [msps_pkg::TypeW-1:0]     trigger_type_o,
  output logic [msps_pkg::SrcIdxW-1:0]   source_index_o,
  output logic                           last_of_tick_o
);

  msps_pkg::ctrl_cmd_t cmd;
  msps_pkg::ctrl_sts_t sts;

  // Sequencing: accept a tick, set up start times once, mark the due
  // sources, then emit them earliest first while advancing each one.
  msps_ctrl #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, comparisons, the divider and the output register. The output
  // register frees the controller as soon as a word is loaded, so the
  // division for the advance runs while the word waits downstream.
  msps_datapath #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .now_time_i     (now_time_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trigger_time_o (trigger_time_o),
    .trigger_type_o (trigger_type_o),
    .source_index_o (source_index_o),
    .last_of_tick_o (last_of_tick_o)
  );

  // Ready for a tick only once every due source of the last one is out.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.fire_any)
    else $error("tick accepted with sources still to emit");

  // Never relaunch the divider while it is working.
  a_div_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider launched while busy");

  // A due time is only written with a finished remainder.
  a_write_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.due_write |-> sts.div_done)
    else $error("due time written before division finished");

  // An accepted tick is never followed by a second one back to back.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second tick accepted back to back");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the periodic trigger scheduler: drives timestamp
// words and register loads, predicts every trigger word and checks them in order.
// Depends on msps_pkg and multi_source_periodic_trigger_scheduler only.
module testbench;
  import msps_pkg::*;

  localparam int unsigned NumSrc       = NumSourcesDef;
  localparam int unsigned StallLimit   = 4000;  // cycles with no word moving
  localparam int unsigned SettleCycles = 400;   // covers the first-tick start-up
  localparam int unsigned PrintCap     = 30;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseTicks   = 60;

  typedef struct {
    logic [TimeW-1:0]   due_time;
    logic [TypeW-1:0]   code;
    logic [SrcIdxW-1:0] src;
    logic               last;
  } trig_word_t;

  // Own copy of the scheduler: registers, due times and the trigger words
  // still owed by the block, oldest first.
  class trigger_tracker;
    logic [IvW-1:0]   interval [SrcSlots];
    logic [TypeW-1:0] code     [SrcSlots];
    logic [TimeW-1:0] due      [SrcSlots];
    bit               started;
    trig_word_t       owed_words[$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < SrcSlots; i++) begin
        interval[i] = '0;
        code[i]     = '0;
        due[i]      = '0;
      end
      started = 1'b0;
      errors  = 0;
    endfunction

    // next multiple of iv strictly above base, wrapping at 64 bits
    function logic [TimeW-1:0] step_up(logic [TimeW-1:0] base, logic [TimeW-1:0] iv);
      return (base / iv + 64'd1) * iv;
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx >= CfgTypeCode0) code[idx - CfgTypeCode0] = data[TypeW-1:0];
      else interval[idx - CfgInterval0] = data[IvW-1:0];
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PrintCap) $display("%0t mismatch: %s", $time, msg);
    endtask

    function void note_tick(logic [TimeW-1:0] now);
      bit         fire [SrcSlots];
      int         order[$];
      int         best;
      int         s;
      trig_word_t w;
      if (!started) begin
        for (int i = 0; i < NumSrc; i++)
          if (interval[i] != '0)
            due[i] = step_up(now + TimeW'(i) * StartStagger, TimeW'(interval[i]));
        started = 1'b1;
      end
      for (int i = 0; i < SrcSlots; i++)
        fire[i] = (i < NumSrc) && (interval[i] != '0) && (due[i] <= now);
      for (int k = 0; k < NumSrc; k++) begin
        best = -1;
        for (int i = 0; i < NumSrc; i++)
          if (fire[i] && (best < 0 || due[i] < due[best])) best = i;
        if (best < 0) break;
        fire[best] = 1'b0;
        order = {order, best};
      end
      foreach (order[k]) begin
        s          = order[k];
        w.due_time = due[s];
        w.code     = code[s];
        w.src      = SrcIdxW'(s);
        w.last     = (k == order.size() - 1);
        owed_words = {owed_words, w};
        due[s] = step_up(due[s], TimeW'(interval[s]));
      end
    endfunction

    task check_word(trig_word_t got);
      trig_word_t want;
      if (owed_words.size() == 0) begin
        report($sformatf("unexpected trigger word time=%h src=%0d", got.due_time, got.src));
        return;
      end
      want = owed_words.pop_front();
      if (got.due_time !== want.due_time)
        report($sformatf("trigger_time %h, want %h", got.due_time, want.due_time));
      if (got.code !== want.code)
        report($sformatf("trigger_type %h, want %h", got.code, want.code));
      if (got.src !== want.src)
        report($sformatf("source_index %0d, want %0d", got.src, want.src));
      if (got.last !== want.last)
        report($sformatf("last_of_tick %b, want %b", got.last, want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = '0;
  logic [CfgW-1:0]      cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [TimeW-1:0]     now_time  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TimeW-1:0]     trigger_time;
  logic [TypeW-1:0]     trigger_type;
  logic [SrcIdxW-1:0]   source_index;
  logic                 last_of_tick;

  trigger_tracker       sb;
  trig_word_t           seen_word;
  logic [IvW-1:0]       plan_iv [SrcSlots];
  logic [TypeW-1:0]     plan_tc [SrcSlots];
  bit                   calm       = 1'b0;  // no idling on either side
  int                   stall_left = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          ticks_in  = 0;
  int unsigned          words_out = 0;
  int unsigned          loads     = 0;

  multi_source_periodic_trigger_scheduler #(
    .NUM_SOURCES(NumSrc)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .now_time_i     (now_time),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .trigger_time_o (trigger_time),
    .trigger_type_o (trigger_type),
    .source_index_o (source_index),
    .last_of_tick_o (last_of_tick)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels and the register port at the rising edge. Check the
  // outgoing word before noting a new tick: it can only belong to older ones.
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (cfg_we) begin
        sb.set_reg(cfg_idx, cfg_wdata);
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        seen_word.due_time = trigger_time;
        seen_word.code     = trigger_type;
        seen_word.src      = source_index;
        seen_word.last     = last_of_tick;
        sb.check_word(seen_word);
        words_out++;
        idle_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        sb.note_tick(now_time);
        ticks_in++;
        idle_cycles = 0;
      end
    end
  end

  // Hold off the trigger words in random bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Abort when nothing has moved for far longer than the slowest word needs.
  initial begin
    wait (idle_cycles >= StallLimit);
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [TimeW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Present one timestamp word, maybe after a short gap, and hold it until
  // taken. Return at the falling edge after the accepting edge.
  task automatic send_tick(input logic [TimeW-1:0] t);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    now_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain every owed word, then give a tick that fired nothing time to finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write all eight registers back to back from the plan arrays.
  task automatic load_plan();
    for (int i = 0; i < SrcSlots; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CfgInterval0 + CfgIdxW'(i);
      cfg_wdata <= plan_iv[i];
      @(negedge clk);
    end
    for (int i = 0; i < SrcSlots; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CfgTypeCode0 + CfgIdxW'(i);
      cfg_wdata <= CfgW'(plan_tc[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    loads++;
  endtask

  initial begin
    logic [TimeW-1:0] opening[$];
    logic [TimeW-1:0] tnow;
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] lo;
    int               sel;
    int               roll;
    int               enabled;

    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Source 1 starts disabled, source 3 has the widest interval. Take the
    // first tick just below the top of the range so the staggered start
    // times of sources 2 and 3 wrap and fire at once; repeat the top value
    // until source 0 wraps as it advances, then go back in time.
    plan_iv[0] = 48'd1000;
    plan_iv[1] = '0;
    plan_iv[2] = 48'd7;
    plan_iv[3] = '1;
    plan_tc[0] = 8'h00;
    plan_tc[1] = 8'hFF;
    plan_tc[2] = 8'hA5;
    plan_tc[3] = 8'h5A;
    load_plan();
    opening = {64'hFFFF_FFFF_FFFF_E0C0};
    repeat (9) opening = {opening, 64'hFFFF_FFFF_FFFF_FFFF};
    opening = {opening, 64'd0, 64'd500, 64'd100, 64'd1_000_000};
    foreach (opening[k]) send_tick(opening[k]);
    settle();

    // Enable source 1 after start (held due time of zero), shrink source 0's
    // interval without recomputing its due time, and disable source 2.
    plan_iv[0] = 48'd1;
    plan_iv[1] = 48'd300;
    plan_iv[2] = '0;
    plan_tc[0] = 8'h3C;
    plan_tc[1] = 8'hC3;
    plan_tc[2] = 8'h00;
    plan_tc[3] = 8'hFF;
    load_plan();
    opening = {64'd2_000_000, 64'd2_000_000, 64'd2_000_001, 64'd0,
               64'hFFFF_FFFF_FFFF_FFFF, 64'd3};
    foreach (opening[k]) send_tick(opening[k]);

    // Random phases: all-unit and all-ones intervals first, then mixed
    // settings. Most ticks walk forward from the earliest due time by up to
    // two intervals of some enabled source; the rest are noise or go back.
    for (int p = 0; p < RandPhases; p++) begin
      enabled = 0;
      for (int i = 0; i < SrcSlots; i++) begin
        if (p == 0) plan_iv[i] = 48'd1;
        else if (p == 1) plan_iv[i] = '1;
        else begin
          case ($urandom_range(0, 5))
            0:       plan_iv[i] = '0;
            1:       plan_iv[i] = IvW'($urandom_range(1, 16));
            2:       plan_iv[i] = IvW'($urandom_range(1, 5000));
            3:       plan_iv[i] = IvW'(rand64());
            4:       plan_iv[i] = '1;
            default: plan_iv[i] = IvW'($urandom_range(1, 100000));
          endcase
        end
        plan_tc[i] = TypeW'($urandom);
        if (i < NumSrc && plan_iv[i] != '0) enabled++;
      end
      if (enabled == 0) plan_iv[0] = IvW'($urandom_range(1, 5000));
      calm = (p == RandPhases - 1) || ($urandom_range(0, 3) == 0);
      settle();
      load_plan();

      lo = '1;
      for (int i = 0; i < NumSrc; i++)
        if (plan_iv[i] != '0 && sb.due[i] < lo) lo = sb.due[i];
      tnow = (lo > 64'd50) ? lo - TimeW'($urandom_range(0, 50)) : lo;

      for (int n = 0; n < PhaseTicks; n++) begin
        do sel = $urandom_range(0, NumSrc - 1); while (plan_iv[sel] == '0);
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          t = rand64();
        end else if (roll < 13) begin
          t = tnow - TimeW'($urandom_range(0, 1000));
        end else begin
          tnow = tnow + rand64() % (64'd2 * TimeW'(plan_iv[sel]) + 64'd1);
          t = tnow;
        end
        send_tick(t);
      end
    end

    settle();
    $display("run covered %0d timestamp words, %0d trigger words, %0d register loads",
             ticks_in, words_out, loads);
    $display("mismatches counted: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
